FILE: rtl/ftvd_pkg.sv
package ftvd_pkg;

  localparam int VERTEX_DEPTH     = 1024;
  localparam int IDX_W            = $clog2(VERTEX_DEPTH);
  localparam int CNT_W            = IDX_W + 1;
  localparam int MAX_FACE_CORNERS = 255;
  localparam int MIN_FACE_CORNERS = 3;
  localparam int POS_W            = 8;
  localparam logic [POS_W-1:0] POS_CAP = '1;

  localparam logic [1:0] SPACE_MESH = 2'd0;
  localparam logic [1:0] SPACE_GRID = 2'd1;

  localparam logic [1:0] KIND_VERTEX   = 2'd0;
  localparam logic [1:0] KIND_TRIANGLE = 2'd1;
  localparam logic [1:0] KIND_EDGE     = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [31:0]      point_id;
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    logic [IDX_W-1:0] index_c;
    logic [15:0]      tri_kind;
    logic             overflow;
    logic             last;
  } result_t;

endpackage

FILE: rtl/ftvd_ram.sv
module ftvd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/fan_triangulator_vertex_dedup_top.sv
// Each point lookup scans the stored vertex table through one RAM read port and one
// comparator, one entry per cycle. A mesh corner takes one lookup, a grid edge two;
// skipped items take no lookup. A stalled output holds the block while a result waits.
// Reset clears the control state and the vertex count; the table contents are not
// cleared, since entries at or above the count are never compared.
module fan_triangulator_vertex_dedup_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [1:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     start_set_i,
  input  logic [31:0]              point_a_i,
  input  logic [31:0]              point_b_i,
  input  logic                     first_of_face_i,
  input  logic [7:0]               face_corners_i,
  input  logic [15:0]              face_kind_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               kind_o,
  output logic [31:0]              point_id_o,
  output logic [ftvd_pkg::IDX_W-1:0] index_a_o,
  output logic [ftvd_pkg::IDX_W-1:0] index_b_o,
  output logic [ftvd_pkg::IDX_W-1:0] index_c_o,
  output logic [15:0]              tri_kind_o,
  output logic                     overflow_o,
  output logic                     last_o
);
  import ftvd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_PUSH   = 3'd2;
  localparam logic [2:0] S_POST   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [1:0]       phase_q, phase_d;
  logic [1:0]       space_kind_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] first_q, first_d, prev_q, prev_d;
  logic [POS_W-1:0] pos_q, pos_d, cur_pos_q, cur_pos_d;
  logic             dropped_q, dropped_d;
  logic             grid_q, grid_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             cmp_v_q, cmp_v_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             lk_ok_q, lk_ok_d, oka_q, oka_d;
  logic [IDX_W-1:0] lk_idx_q, lk_idx_d, idxa_q, idxa_d;
  logic [31:0]      pt_q, pt_d, pb_q, pb_d;
  logic [15:0]      fkind_q, fkind_d;
  result_t          res_q, res_d, pend_q, pend_d, out_q, out_d;
  logic             pend_v_q, pend_v_d, out_v_q, out_v_d;

  logic             ram_we;
  logic [31:0]      ram_rdata;
  logic             out_free;
  logic             hit;
  logic [POS_W-1:0] p;
  logic             drop;

  ftvd_ram #(
    .WIDTH(32),
    .DEPTH(VERTEX_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i(pt_q),
    .raddr_i(rd_idx_q[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign pready = 1'b1;
  assign prdata = {30'd0, space_kind_q};

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_v_q;
  assign kind_o      = out_q.kind;
  assign point_id_o  = out_q.point_id;
  assign index_a_o   = out_q.index_a;
  assign index_b_o   = out_q.index_b;
  assign index_c_o   = out_q.index_c;
  assign tri_kind_o  = out_q.tri_kind;
  assign overflow_o  = out_q.overflow;
  assign last_o      = out_q.last;

  assign out_free = !out_v_q || !out_stall_i;
  assign hit      = cmp_v_q && (ram_rdata == pt_q);
  assign p        = first_of_face_i ? '0 : pos_q;
  assign drop     = first_of_face_i ? 1'b0 : dropped_q;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    count_d   = count_q;
    first_d   = first_q;
    prev_d    = prev_q;
    pos_d     = pos_q;
    cur_pos_d = cur_pos_q;
    dropped_d = dropped_q;
    grid_d    = grid_q;
    rd_idx_d  = rd_idx_q;
    cmp_v_d   = cmp_v_q;
    cmp_idx_d = cmp_idx_q;
    lk_ok_d   = lk_ok_q;
    lk_idx_d  = lk_idx_q;
    oka_d     = oka_q;
    idxa_d    = idxa_q;
    pt_d      = pt_q;
    pb_d      = pb_q;
    fkind_d   = fkind_q;
    res_d     = res_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    out_d     = out_q;
    out_v_d   = out_v_q && out_stall_i;
    ram_we    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pt_d     = point_a_i;
          pb_d     = point_b_i;
          fkind_d  = face_kind_i;
          rd_idx_d = '0;
          cmp_v_d  = 1'b0;
          phase_d  = 2'd0;
          grid_d   = (space_kind_q == SPACE_GRID);
          if (space_kind_q == SPACE_GRID) begin
            if (start_set_i) begin
              count_d = '0;
            end
            state_d = S_SCAN;
          end else if (space_kind_q == SPACE_MESH) begin
            if (start_set_i) begin
              count_d = '0;
            end
            dropped_d = drop;
            cur_pos_d = p;
            pos_d     = (p < POS_CAP) ? p + POS_W'(1) : p;
            if ((32'(face_corners_i) >= MIN_FACE_CORNERS) &&
                (32'(face_corners_i) <= MAX_FACE_CORNERS) &&
                (p < face_corners_i) && !drop) begin
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          cmp_v_d  = 1'b0;
          lk_ok_d  = 1'b1;
          lk_idx_d = cmp_idx_q;
          state_d  = S_POST;
        end else if (rd_idx_q < count_q) begin
          rd_idx_d  = rd_idx_q + CNT_W'(1);
          cmp_v_d   = 1'b1;
          cmp_idx_d = rd_idx_q[IDX_W-1:0];
        end else begin
          cmp_v_d        = 1'b0;
          res_d          = '0;
          res_d.kind     = KIND_VERTEX;
          res_d.point_id = pt_q;
          if (count_q >= CNT_W'(VERTEX_DEPTH)) begin
            res_d.overflow = 1'b1;
            lk_ok_d        = 1'b0;
          end else begin
            ram_we        = 1'b1;
            res_d.index_a = count_q[IDX_W-1:0];
            lk_ok_d       = 1'b1;
            lk_idx_d      = count_q[IDX_W-1:0];
            count_d       = count_q + CNT_W'(1);
          end
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_d   = pend_q;
            out_v_d = 1'b1;
          end
          pend_d   = res_q;
          pend_v_d = 1'b1;
          state_d  = S_POST;
        end
      end
      S_POST: begin
        if (phase_q == 2'd2) begin
          state_d = S_FINISH;
        end else if (grid_q) begin
          if (phase_q == 2'd0) begin
            oka_d    = lk_ok_q;
            idxa_d   = lk_idx_q;
            pt_d     = pb_q;
            rd_idx_d = '0;
            cmp_v_d  = 1'b0;
            phase_d  = 2'd1;
            state_d  = S_SCAN;
          end else begin
            phase_d = 2'd2;
            if (oka_q && lk_ok_q) begin
              res_d         = '0;
              res_d.kind    = KIND_EDGE;
              res_d.index_a = idxa_q;
              res_d.index_b = lk_idx_q;
              state_d       = S_PUSH;
            end else begin
              state_d = S_FINISH;
            end
          end
        end else begin
          phase_d = 2'd2;
          state_d = S_FINISH;
          if (!lk_ok_q) begin
            dropped_d = 1'b1;
          end else if (cur_pos_q == '0) begin
            first_d = lk_idx_q;
          end else if (cur_pos_q == POS_W'(1)) begin
            prev_d = lk_idx_q;
          end else begin
            res_d          = '0;
            res_d.kind     = KIND_TRIANGLE;
            res_d.index_a  = first_q;
            res_d.index_b  = prev_q;
            res_d.index_c  = lk_idx_q;
            res_d.tri_kind = fkind_q;
            prev_d         = lk_idx_q;
            state_d        = S_PUSH;
          end
        end
      end
      S_FINISH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_v_d    = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= 2'd0;
      space_kind_q <= SPACE_MESH;
      count_q      <= '0;
      first_q      <= '0;
      prev_q       <= '0;
      pos_q        <= '0;
      dropped_q    <= 1'b0;
      cmp_v_q      <= 1'b0;
      pend_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      count_q   <= count_d;
      first_q   <= first_d;
      prev_q    <= prev_d;
      pos_q     <= pos_d;
      dropped_q <= dropped_d;
      cmp_v_q   <= cmp_v_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
      if (psel && penable && pwrite) begin
        space_kind_q <= pwdata[1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_pos_q <= cur_pos_d;
    grid_q    <= grid_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    lk_ok_q   <= lk_ok_d;
    lk_idx_q  <= lk_idx_d;
    oka_q     <= oka_d;
    idxa_q    <= idxa_d;
    pt_q      <= pt_d;
    pb_q      <= pb_d;
    fkind_q   <= fkind_d;
    res_q     <= res_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

endmodule

FILE: tb/ftvd_result_check.sv
`timescale 1ns / 1ps
module ftvd_result_check #(
  parameter logic [1:0] SPACE_KIND_ADDR = 2'd0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [1:0]                 paddr_i,
  input  logic [31:0]                pwdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic                       start_set_i,
  input  logic [31:0]                point_a_i,
  input  logic [31:0]                point_b_i,
  input  logic                       first_of_face_i,
  input  logic [7:0]                 face_corners_i,
  input  logic [15:0]                face_kind_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [1:0]                 kind_i,
  input  logic [31:0]                point_id_i,
  input  logic [ftvd_pkg::IDX_W-1:0] index_a_i,
  input  logic [ftvd_pkg::IDX_W-1:0] index_b_i,
  input  logic [ftvd_pkg::IDX_W-1:0] index_c_i,
  input  logic [15:0]                tri_kind_i,
  input  logic                       overflow_i,
  input  logic                       last_i,
  output int                         mismatches_o,
  output int                         outstanding_o
);
  import ftvd_pkg::*;

  logic [31:0]      vertex_ids [VERTEX_DEPTH];
  logic [CNT_W-1:0] vertex_total;
  logic [IDX_W-1:0] fan_first;
  logic [IDX_W-1:0] fan_prev;
  logic [POS_W-1:0] corner_pos;
  logic             face_dropped;
  logic [1:0]       space_kind;
  result_t          due_q [$];
  result_t          item_q [$];
  result_t          head;
  int               fail_count = 0;
  int               due_count = 0;

  assign mismatches_o  = fail_count;
  assign outstanding_o = due_count;

  function automatic bit find_or_append(input logic [31:0] pt, output logic [IDX_W-1:0] idx);
    result_t r;
    r = '0;
    r.kind = KIND_VERTEX;
    r.point_id = pt;
    idx = '0;
    for (int i = 0; i < int'(vertex_total); i++) begin
      if (vertex_ids[i] == pt) begin
        idx = IDX_W'(i);
        return 1'b1;
      end
    end
    if (vertex_total >= CNT_W'(VERTEX_DEPTH)) begin
      r.overflow = 1'b1;
      item_q.push_back(r);
      return 1'b0;
    end
    idx = vertex_total[IDX_W-1:0];
    vertex_ids[idx] = pt;
    vertex_total++;
    r.index_a = idx;
    item_q.push_back(r);
    return 1'b1;
  endfunction

  task automatic dedup_and_fan();
    logic [IDX_W-1:0] ia;
    logic [IDX_W-1:0] ib;
    logic [POS_W-1:0] pos;
    bit               ok_a;
    bit               ok_b;
    result_t          r;
    item_q.delete();
    if (space_kind == SPACE_MESH || space_kind == SPACE_GRID) begin
      if (start_set_i) vertex_total = '0;
      if (space_kind == SPACE_GRID) begin
        ok_a = find_or_append(point_a_i, ia);
        ok_b = find_or_append(point_b_i, ib);
        if (ok_a && ok_b) begin
          r = '0;
          r.kind = KIND_EDGE;
          r.index_a = ia;
          r.index_b = ib;
          item_q.push_back(r);
        end
      end else begin
        if (first_of_face_i) begin
          corner_pos = '0;
          face_dropped = 1'b0;
        end
        pos = corner_pos;
        if (corner_pos != POS_CAP) corner_pos++;
        if (face_corners_i >= MIN_FACE_CORNERS && face_corners_i <= MAX_FACE_CORNERS &&
            pos < face_corners_i && !face_dropped) begin
          if (!find_or_append(point_a_i, ia)) begin
            face_dropped = 1'b1;
          end else if (pos == 0) begin
            fan_first = ia;
          end else if (pos == 1) begin
            fan_prev = ia;
          end else begin
            r = '0;
            r.kind = KIND_TRIANGLE;
            r.index_a = fan_first;
            r.index_b = fan_prev;
            r.index_c = ia;
            r.tri_kind = face_kind_i;
            item_q.push_back(r);
            fan_prev = ia;
          end
        end
      end
    end
    if (item_q.size() > 0) begin
      r = item_q.pop_back();
      r.last = 1'b1;
      item_q.push_back(r);
      foreach (item_q[i]) due_q.push_back(item_q[i]);
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Handshake signals are sampled on the falling edge; a transfer seen here
  // completes at the next rising edge.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_total = '0;
      fan_first = '0;
      fan_prev = '0;
      corner_pos = '0;
      face_dropped = 1'b0;
      space_kind = SPACE_MESH;
      due_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == SPACE_KIND_ADDR) begin
        space_kind = pwdata_i[1:0];
      end
      if (in_valid_i && !in_stall_i) dedup_and_fan();
      if (out_valid_i && !out_stall_i) begin
        if (due_q.size() == 0) begin
          $error("unexpected transfer: kind %0h point_id %0h", kind_i, point_id_i);
          fail_count++;
        end else begin
          head = due_q.pop_front();
          check_field("kind", head.kind, kind_i);
          check_field("point_id", head.point_id, point_id_i);
          check_field("index_a", head.index_a, index_a_i);
          check_field("index_b", head.index_b, index_b_i);
          check_field("index_c", head.index_c, index_c_i);
          check_field("tri_kind", head.tri_kind, tri_kind_i);
          check_field("overflow", head.overflow, overflow_i);
          check_field("last", head.last, last_i);
        end
      end
    end
    due_count = due_q.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ftvd_pkg::*;

  localparam logic [1:0]  SPACE_KIND_ADDR = 2'd0;
  localparam logic [1:0]  SPACE_IGNORED   = 2'd2;
  localparam int          DRAIN_CYCLES    = 2 * (VERTEX_DEPTH + 2) + 16;
  localparam int          POOL_SIZE       = 16;
  localparam int          HOLD_CYCLES     = 400;
  localparam int          PHASE_ITEMS     = 12;
  localparam int          IGNORED_ITEMS   = 6;
  localparam logic [31:0] FILL_BASE       = 32'h1000_0000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [1:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             start_set_i;
  logic [31:0]      point_a_i;
  logic [31:0]      point_b_i;
  logic             first_of_face_i;
  logic [7:0]       face_corners_i;
  logic [15:0]      face_kind_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [1:0]       kind_o;
  logic [31:0]      point_id_o;
  logic [IDX_W-1:0] index_a_o;
  logic [IDX_W-1:0] index_b_o;
  logic [IDX_W-1:0] index_c_o;
  logic [15:0]      tri_kind_o;
  logic             overflow_o;
  logic             last_o;

  int          mismatches;
  int          outstanding;
  int          items_sent = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  logic [31:0] pool [POOL_SIZE];

  always #1 clk_i = ~clk_i;

  fan_triangulator_vertex_dedup_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .start_set_i     (start_set_i),
    .point_a_i       (point_a_i),
    .point_b_i       (point_b_i),
    .first_of_face_i (first_of_face_i),
    .face_corners_i  (face_corners_i),
    .face_kind_i     (face_kind_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .point_id_o      (point_id_o),
    .index_a_o       (index_a_o),
    .index_b_o       (index_b_o),
    .index_c_o       (index_c_o),
    .tri_kind_o      (tri_kind_o),
    .overflow_o      (overflow_o),
    .last_o          (last_o)
  );

  ftvd_result_check #(
    .SPACE_KIND_ADDR (SPACE_KIND_ADDR)
  ) u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .start_set_i     (start_set_i),
    .point_a_i       (point_a_i),
    .point_b_i       (point_b_i),
    .first_of_face_i (first_of_face_i),
    .face_corners_i  (face_corners_i),
    .face_kind_i     (face_kind_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_i          (kind_o),
    .point_id_i      (point_id_o),
    .index_a_i       (index_a_o),
    .index_b_i       (index_b_o),
    .index_c_i       (index_c_o),
    .tri_kind_i      (tri_kind_o),
    .overflow_i      (overflow_o),
    .last_i          (last_o),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding)
  );

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= !calm && $urandom_range(0, 99) < 32;
      end
    end
  end

  initial begin
    #40_000_000;
    $display("[fan_triangulator_vertex_dedup_top] ERROR");
    $finish;
  end

  task automatic send_item(input logic sset, input logic [31:0] pa, input logic [31:0] pb,
                           input logic first, input logic [7:0] corners,
                           input logic [15:0] fkind);
    if (!calm && $urandom_range(0, 99) < 32) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    start_set_i     <= sset;
    point_a_i       <= pa;
    point_b_i       <= pb;
    first_of_face_i <= first;
    face_corners_i  <= corners;
    face_kind_i     <= fkind;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
  endtask

  task automatic write_space_kind(input logic [1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SPACE_KIND_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_point();
    if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic mesh_faces(input int quota);
    int          goal;
    int          pick;
    int          declared;
    int          sent;
    logic [15:0] fkind;
    logic        sset;
    logic        first;
    bit          opening;
    goal = items_sent + quota;
    opening = 1'b1;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) declared = $urandom_range(0, 2);
      else if (pick < 14) declared = $urandom_range(9, 255);
      else declared = $urandom_range(3, 8);
      sent = (declared > 10) ? $urandom_range(3, 10) : declared;
      pick = $urandom_range(0, 99);
      if (pick < 10) sent += $urandom_range(1, 2);
      else if (pick < 20 && sent > 1) sent -= 1;
      if (sent == 0) sent = 1;
      fkind = 16'($urandom);
      for (int c = 0; c < sent; c++) begin
        sset  = opening || (c == 0 && $urandom_range(0, 5) == 0) || $urandom_range(0, 49) == 0;
        first = (c == 0) && $urandom_range(0, 19) != 0;
        send_item(sset, random_point(), $urandom, first, 8'(declared), fkind);
        opening = 1'b0;
      end
    end
  endtask

  task automatic grid_edges(input int quota);
    logic [31:0] pa;
    for (int k = 0; k < quota; k++) begin
      pa = random_point();
      send_item(k == 0 || $urandom_range(0, 19) == 0, pa,
                ($urandom_range(0, 9) == 0) ? pa : random_point(),
                1'($urandom), 8'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_valid_i      <= 1'b0;
    start_set_i     <= 1'b0;
    point_a_i       <= '0;
    point_b_i       <= '0;
    first_of_face_i <= 1'b0;
    face_corners_i  <= '0;
    face_kind_i     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_space_kind(SPACE_MESH);
    send_item(1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 8'd3, 16'h0000);
    send_item(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 8'd3, 16'h0000);
    send_item(1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'd3, 16'hFFFF);
    send_item(1'b0, 32'h0BAD_0001, 32'h0000_0000, 1'b0, 8'd3, 16'h1234);
    send_item(1'b0, 32'h0BAD_0002, 32'h0000_0000, 1'b1, 8'd0, 16'h1234);
    send_item(1'b0, 32'h0BAD_0003, 32'h0000_0000, 1'b1, 8'd2, 16'h1234);
    send_item(1'b0, 32'hA5A5_A5A5, 32'h0000_0000, 1'b1, 8'd255, 16'h8001);
    send_item(1'b0, 32'h5A5A_5A5A, 32'h0000_0000, 1'b0, 8'd255, 16'h8001);
    send_item(1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'd255, 16'h8001);
    send_item(1'b0, 32'h1234_5678, 32'h0000_0000, 1'b1, 8'd4, 16'h00FF);
    send_item(1'b0, 32'h8765_4321, 32'h0000_0000, 1'b0, 8'd4, 16'h00FF);
    send_item(1'b1, 32'hCAFE_F00D, 32'h0000_0000, 1'b0, 8'd4, 16'h00FF);
    drain();

    write_space_kind(SPACE_GRID);
    send_item(1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 8'd0, 16'h0000);
    send_item(1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 8'd0, 16'h0000);
    send_item(1'b0, 32'h7777_7777, 32'h7777_7777, 1'b0, 8'd0, 16'h0000);
    drain();
    write_space_kind(SPACE_IGNORED);
    send_item(1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 8'd3, 16'hFFFF);
    send_item(1'b1, 32'h1111_1111, 32'h2222_2222, 1'b0, 8'd5, 16'h0001);
    drain();
    write_space_kind(SPACE_GRID);
    send_item(1'b0, 32'h7777_7777, 32'hFFFF_FFFF, 1'b0, 8'd0, 16'h0000);

    // Fill the whole vertex table with distinct points, then push past it.
    for (int k = 0; k < VERTEX_DEPTH / 2; k++) begin
      send_item(k == 0, FILL_BASE + 32'(2 * k), FILL_BASE + 32'(2 * k + 1), 1'b0, 8'd0, 16'd0);
    end
    send_item(1'b0, FILL_BASE + 32'd1022, FILL_BASE + 32'd1023, 1'b0, 8'd0, 16'd0);
    send_item(1'b0, 32'hCAFE_0001, FILL_BASE, 1'b0, 8'd0, 16'd0);
    send_item(1'b0, FILL_BASE + 32'd5, 32'hCAFE_0002, 1'b0, 8'd0, 16'd0);
    drain();
    write_space_kind(SPACE_MESH);
    send_item(1'b0, FILL_BASE + 32'd1023, 32'h0, 1'b1, 8'd4, 16'hBEEF);
    send_item(1'b0, FILL_BASE, 32'h0, 1'b0, 8'd4, 16'hBEEF);
    send_item(1'b0, 32'hDEAD_BEEF, 32'h0, 1'b0, 8'd4, 16'hBEEF);
    send_item(1'b0, FILL_BASE + 32'd7, 32'h0, 1'b0, 8'd4, 16'hBEEF);
    send_item(1'b0, FILL_BASE + 32'd1022, 32'h0, 1'b1, 8'd3, 16'h4321);
    send_item(1'b0, FILL_BASE + 32'd1023, 32'h0, 1'b0, 8'd3, 16'h4321);
    send_item(1'b0, FILL_BASE + 32'd1, 32'h0, 1'b0, 8'd3, 16'h4321);

    for (int p = 0; p < 6; p++) begin
      drain();
      foreach (pool[i]) pool[i] = $urandom;
      calm = (p == 2);
      case (p)
        0: begin
          write_space_kind(SPACE_MESH);
          hold_req = 1'b1;
          mesh_faces(PHASE_ITEMS);
        end
        1, 4: begin
          write_space_kind(SPACE_GRID);
          grid_edges(PHASE_ITEMS);
        end
        3: begin
          write_space_kind(SPACE_IGNORED);
          for (int k = 0; k < IGNORED_ITEMS; k++) begin
            send_item(1'($urandom), $urandom, $urandom, 1'($urandom), 8'($urandom),
                      16'($urandom));
          end
        end
        default: begin
          write_space_kind(SPACE_MESH);
          mesh_faces(PHASE_ITEMS);
        end
      endcase
    end
    calm = 1'b0;
    drain();

    if (mismatches == 0 && outstanding == 0) begin
      $display("[fan_triangulator_vertex_dedup_top] OK");
    end else begin
      $display("[fan_triangulator_vertex_dedup_top] ERROR");
    end
    $finish;
  end

endmodule
